// ----- hw/rtl/wse_pkg.sv -----
// shared types, constants and functions for the weighted simhash encoder
package wse_pkg;

    localparam int unsigned DefMaxBits  = 256;
    localparam int unsigned DefMaxRanks = 4;
    localparam int unsigned RankRegs    = 4;
    localparam int unsigned MaxWords    = 4;
    localparam int unsigned VoteW       = 48;

    localparam logic [63:0] Mix1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] Mix2 = 64'hc4ceb9fe1a85ec53;

    localparam logic [2:0] RegRankCount = 3'd0;
    localparam logic [2:0] RegRank0     = 3'd1;
    localparam logic [2:0] RegRank1     = 3'd2;
    localparam logic [2:0] RegRank2     = 3'd3;
    localparam logic [2:0] RegRank3     = 3'd4;
    localparam logic [2:0] RegFillLow   = 3'd5;
    localparam logic [2:0] RegFillHigh  = 3'd6;

    localparam logic KindFeature = 1'b0;
    localparam logic KindFinish  = 1'b1;

    typedef enum logic [1:0] {
        MIX_IDLE,
        MIX_MUL1,
        MIX_MUL2,
        MIX_DONE
    } mix_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_VOTE_RD,
        ST_VOTE_WR,
        ST_FILL_CHK,
        ST_FILL_HASH,
        ST_EMIT_RD,
        ST_EMIT_ACC,
        ST_EMIT_OUT,
        ST_CLEAR
    } state_t;

    // saturating 48-bit add of two 48-bit signed values
    function automatic logic [VoteW-1:0] sat_add(input logic [VoteW-1:0] a,
                                                 input logic [VoteW-1:0] d);
        logic [VoteW:0] s;
        s = {a[VoteW-1], a} + {d[VoteW-1], d};
        if (s[VoteW] != s[VoteW-1])
            return s[VoteW] ? {1'b1, {(VoteW-1){1'b0}}} : {1'b0, {(VoteW-1){1'b1}}};
        return s[VoteW-1:0];
    endfunction

endpackage

// ----- hw/rtl/wse_ram.sv -----
// generic single-port ram with registered read
module wse_ram #(
    parameter int unsigned Width = 48,
    parameter int unsigned Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ----- hw/rtl/wse_mix.sv -----
// murmur3 fmix64 unit, 64-bit products built from a shared 32x32 multiplier
module wse_mix (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] seed,
    output logic        done,
    output logic [63:0] hash
);
    import wse_pkg::*;

    mix_state_t  state_reg, state_next;
    logic [1:0]  part_reg, part_next;
    logic [63:0] k_reg, k_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] c;
    logic [31:0] op_a, op_b;
    logic [63:0] prod;
    logic [63:0] full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MIX_IDLE;
            part_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            part_reg  <= part_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        acc_reg <= acc_next;
    end

    // low 64 bits of k * c: lo*lo, then lo*hi and hi*lo folded into the top half
    always_comb
    begin
        state_next = state_reg;
        part_next  = part_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        c          = (state_reg == MIX_MUL2) ? Mix2 : Mix1;
        op_a       = (part_reg == 2'd2) ? k_reg[63:32] : k_reg[31:0];
        op_b       = (part_reg == 2'd1) ? c[63:32] : c[31:0];
        prod       = 64'(op_a) * 64'(op_b);
        full       = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
        unique case (state_reg)
            MIX_IDLE, MIX_DONE:
            begin
                if (go)
                begin
                    k_next     = seed ^ (seed >> 33);
                    part_next  = '0;
                    state_next = MIX_MUL1;
                end
                else
                    state_next = MIX_IDLE;
            end
            MIX_MUL1, MIX_MUL2:
            begin
                if (part_reg == 2'd0)
                begin
                    acc_next  = prod;
                    part_next = 2'd1;
                end
                else if (part_reg == 2'd1)
                begin
                    acc_next  = full;
                    part_next = 2'd2;
                end
                else
                begin
                    k_next     = full ^ (full >> 33);
                    part_next  = '0;
                    state_next = (state_reg == MIX_MUL1) ? MIX_MUL2 : MIX_DONE;
                end
            end
            default: state_next = MIX_IDLE;
        endcase
    end

    assign done = (state_reg == MIX_DONE);
    assign hash = k_reg;
endmodule

// ----- hw/rtl/weighted_simhash_encoder.sv -----
// top level of the weighted simhash encoder
// Items enter by start while busy is low. A feature item hashes its rank's
// slice with a chain of fmix64 hashes (each of six 32x32 multiply steps on
// one shared multiplier) and then updates one vote counter per code bit
// through a single-port vote ram, with a read and a write per bit; a skipped
// feature or one with an empty slice leaves busy low. A finish item checks
// each rank in turn and hashes a stand-in feature into each empty rank with
// a non-empty slice; it then reads the votes back, bit by bit, and puts out
// up to four code words, each valid for one cycle with out_valid, then sweeps
// the vote ram clear, one entry a cycle. The same sweep runs after reset.
// Results cannot be held off by the receiver.
module weighted_simhash_encoder #(
    parameter int unsigned MAX_BITS  = wse_pkg::DefMaxBits,
    parameter int unsigned MAX_RANKS = wse_pkg::DefMaxRanks
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [63:0] feat_id,
    input  logic [2:0]  feature_rank,
    input  logic [31:0] weight,
    input  logic [63:0] record_uid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        out_valid,
    output logic [63:0] code_word,
    output logic [1:0]  word_index,
    output logic        last_word
);
    import wse_pkg::*;

    localparam int unsigned AW  = $clog2(MAX_BITS);
    localparam int unsigned PW  = $clog2(MAX_BITS + 1);
    localparam int unsigned RW  = $clog2(MAX_RANKS > 1 ? MAX_RANKS : 2);
    localparam int unsigned LimR = (MAX_RANKS < RankRegs) ? MAX_RANKS : RankRegs;

    state_t state_reg, state_next;

    logic [2:0]  rank_count_reg;
    logic [8:0]  rank_bits_reg [RankRegs];
    logic [63:0] fill_lo_reg, fill_hi_reg;
    logic [VoteW-1:0] tot_reg [MAX_RANKS];

    logic [63:0] seed_reg, seed_next;
    logic [63:0] h_reg, h_next;
    logic [VoteW-1:0] w_reg, w_next;
    logic [PW-1:0] pos_reg, pos_next;     // next code bit
    logic [PW-1:0] end_reg, end_next;     // end of slice
    logic [5:0]  b_reg, b_next;
    logic [2:0]  r_reg, r_next;
    logic [63:0] cw_reg, cw_next;
    logic        fin_reg, fin_next;
    logic [63:0] uid_reg, uid_next;

    logic        mix_go, mix_done;
    logic [63:0] mix_seed, mix_hash;

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [VoteW-1:0] ram_wdata, ram_rdata;

    // slice geometry
    logic [2:0]  n_eff;
    logic [PW-1:0] sl_start [RankRegs];
    logic [PW-1:0] sl_len   [RankRegs];
    logic [PW-1:0] total;
    logic [2:0]  words;

    always_comb
    begin
        logic [PW:0] p;
        logic [8:0]  b;
        logic [PW:0] room;
        n_eff = rank_count_reg;
        if (n_eff == 3'd0)
            n_eff = 3'd1;
        if (n_eff > 3'(LimR))
            n_eff = 3'(LimR);
        p = '0;
        for (int i = 0; i < RankRegs; i++)
        begin
            b = (rank_bits_reg[i] > 9'd256) ? 9'd256 : rank_bits_reg[i];
            room = (PW+1)'(MAX_BITS) - p;
            if ((PW+1)'(b) > room)
                b = 9'(room);
            if (3'(i) >= n_eff)
                b = '0;
            sl_start[i] = p[PW-1:0];
            sl_len[i]   = PW'(b);
            p = p + (PW+1)'(b);
        end
        total = p[PW-1:0];
        words = (total == '0) ? 3'd1
              : ((PW+1)'(total) > (PW+1)'(MaxWords * 64)) ? 3'(MaxWords)
              : 3'((({1'b0, total} + (PW+1)'(63)) >> 6));
    end

    wse_mix u_mix (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (mix_go),
        .seed (mix_seed),
        .done (mix_done),
        .hash (mix_hash)
    );

    wse_ram #(.Width(VoteW), .Depth(MAX_BITS)) u_votes (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            rank_count_reg <= 3'd1;
            rank_bits_reg[0] <= 9'd256;
            rank_bits_reg[1] <= 9'd0;
            rank_bits_reg[2] <= 9'd0;
            rank_bits_reg[3] <= 9'd0;
            fill_lo_reg    <= 64'd4294968296000000;
            fill_hi_reg    <= 64'd4294968296000000;
            pos_reg        <= '0;
            for (int i = 0; i < MAX_RANKS; i++)
                tot_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    RegRankCount: rank_count_reg   <= cfg_data[2:0];
                    RegRank0:     rank_bits_reg[0] <= cfg_data[8:0];
                    RegRank1:     rank_bits_reg[1] <= cfg_data[8:0];
                    RegRank2:     rank_bits_reg[2] <= cfg_data[8:0];
                    RegRank3:     rank_bits_reg[3] <= cfg_data[8:0];
                    RegFillLow:   fill_lo_reg      <= cfg_data;
                    RegFillHigh:  fill_hi_reg      <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE && start && kind == KindFeature
                && feature_rank < n_eff)
                tot_reg[feature_rank[RW-1:0]] <=
                    sat_add(tot_reg[feature_rank[RW-1:0]],
                            {{(VoteW-32){weight[31]}}, weight});
            if (state_reg == ST_CLEAR && state_next == ST_IDLE)
                for (int i = 0; i < MAX_RANKS; i++)
                    tot_reg[i] <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg <= seed_next;
        h_reg    <= h_next;
        w_reg    <= w_next;
        end_reg  <= end_next;
        b_reg    <= b_next;
        r_reg    <= r_next;
        cw_reg   <= cw_next;
        fin_reg  <= fin_next;
        uid_reg  <= uid_next;
    end

    always_comb
    begin
        logic [VoteW-1:0] fw;
        logic [63:0]      src;
        state_next = state_reg;
        seed_next  = seed_reg;
        h_next     = h_reg;
        w_next     = w_reg;
        pos_next   = pos_reg;
        end_next   = end_reg;
        b_next     = b_reg;
        r_next     = r_reg;
        cw_next    = cw_reg;
        fin_next   = fin_reg;
        uid_next   = uid_reg;
        mix_go     = 1'b0;
        mix_seed   = seed_reg;
        ram_we     = 1'b0;
        ram_addr   = pos_reg[AW-1:0];
        ram_wdata  = sat_add(ram_rdata, h_reg[b_reg] ? w_reg : -w_reg);
        out_valid  = 1'b0;
        src        = r_reg[1] ? fill_hi_reg : fill_lo_reg;
        fw         = r_reg[0] ? {{(VoteW-32){src[63]}}, src[63:32]}
                              : {{(VoteW-32){src[31]}}, src[31:0]};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KindFinish)
                    begin
                        uid_next   = record_uid;
                        r_next     = '0;
                        fin_next   = 1'b1;
                        state_next = ST_FILL_CHK;
                    end
                    else if (feature_rank < n_eff)
                    begin
                        fin_next   = 1'b0;
                        seed_next  = feat_id;
                        w_next     = {{(VoteW-32){weight[31]}}, weight};
                        pos_next   = sl_start[feature_rank[1:0]];
                        end_next   = sl_start[feature_rank[1:0]] + sl_len[feature_rank[1:0]];
                        b_next     = '0;
                        if (sl_len[feature_rank[1:0]] != '0)
                        begin
                            mix_go     = 1'b1;
                            mix_seed   = feat_id;
                            state_next = ST_HASH;
                        end
                    end
                end
            end
            ST_HASH:
            begin
                if (mix_done)
                begin
                    h_next     = mix_hash;
                    seed_next  = mix_hash;
                    b_next     = '0;
                    state_next = ST_VOTE_RD;
                end
            end
            ST_VOTE_RD:
                state_next = ST_VOTE_WR;
            ST_VOTE_WR:
            begin
                ram_we   = 1'b1;
                pos_next = pos_reg + PW'(1);
                b_next   = b_reg + 6'd1;
                if (pos_reg + PW'(1) == end_reg)
                    state_next = fin_reg ? ST_FILL_CHK : ST_IDLE;
                else if (b_reg == 6'd63)
                begin
                    mix_go     = 1'b1;
                    mix_seed   = seed_reg;
                    state_next = ST_HASH;
                end
                else
                    state_next = ST_VOTE_RD;
            end
            ST_FILL_CHK:
            begin
                // either the last rank has been looked at or continue
                if (r_reg >= n_eff)
                begin
                    pos_next   = '0;
                    b_next     = '0;
                    cw_next    = '0;
                    state_next = ST_EMIT_RD;
                end
                else if (tot_reg[r_reg[RW-1:0]] == '0 && sl_len[r_reg[1:0]] != '0)
                begin
                    mix_go     = 1'b1;
                    mix_seed   = uid_reg ^ {29'd0, r_reg, 32'd0};
                    state_next = ST_FILL_HASH;
                end
                else
                    r_next = r_reg + 3'd1;
            end
            ST_FILL_HASH:
            begin
                if (mix_done)
                begin
                    mix_go     = 1'b1;
                    mix_seed   = 64'd0 - mix_hash;
                    seed_next  = 64'd0 - mix_hash;
                    w_next     = fw;
                    pos_next   = sl_start[r_reg[1:0]];
                    end_next   = sl_start[r_reg[1:0]] + sl_len[r_reg[1:0]];
                    b_next     = '0;
                    r_next     = r_reg + 3'd1;
                    state_next = ST_HASH;
                end
            end
            ST_EMIT_RD:
                state_next = ST_EMIT_ACC;
            ST_EMIT_ACC:
            begin
                if (pos_reg < total && !ram_rdata[VoteW-1] && ram_rdata != '0)
                    cw_next[pos_reg[5:0]] = 1'b1;
                pos_next = pos_reg + PW'(1);
                if (pos_reg[5:0] == 6'd63 || pos_reg + PW'(1) == PW'(MAX_BITS))
                    state_next = ST_EMIT_OUT;
                else
                    state_next = ST_EMIT_RD;
            end
            ST_EMIT_OUT:
            begin
                out_valid = 1'b1;
                cw_next   = '0;
                b_next    = b_reg + 6'd1;
                if (3'(b_reg) + 3'd1 == words)
                begin
                    pos_next   = '0;
                    state_next = ST_CLEAR;
                end
                else if (pos_reg >= PW'(MAX_BITS))
                    state_next = ST_EMIT_OUT;
                else
                    state_next = ST_EMIT_RD;
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                pos_next  = pos_reg + PW'(1);
                if (pos_reg == PW'(MAX_BITS - 1))
                begin
                    pos_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy       = (state_reg != ST_IDLE);
    assign code_word  = cw_reg;
    assign word_index = b_reg[1:0];
    assign last_word  = (3'(b_reg) + 3'd1 == words);
endmodule

// ----- dv/weighted_simhash_encoder_test.sv -----
// self-checking testbench for the weighted simhash encoder
module weighted_simhash_encoder_test;
    import wse_pkg::*;

    localparam int unsigned NumBits = 256;
    localparam int unsigned NumRanks = 4;
    localparam int unsigned Settle = 700;
    localparam int unsigned CycleLimit = 3000000;
    localparam int unsigned ItemTarget = 450;
    localparam longint VoteMax = (64'sd1 <<< 47) - 1;
    localparam longint VoteMin = -(64'sd1 <<< 47);

    typedef struct {
        logic [63:0] code;
        logic [1:0]  index;
        logic        last;
    } code_word_t;

    class code_scoreboard;
        logic [2:0]  rank_count;
        logic [8:0]  rank_bits[NumRanks];
        logic [63:0] fill_low;
        logic [63:0] fill_high;
        longint      votes[NumBits];
        longint      rank_sums[NumRanks];
        code_word_t  pending_words[$];
        int          errors;
        int          words_seen;
        int          records;

        function new();
            rank_count = 3'd1;
            rank_bits[0] = 9'd256;
            for (int i = 1; i < NumRanks; i++)
                rank_bits[i] = 9'd0;
            fill_low = 64'd4294968296000000;
            fill_high = 64'd4294968296000000;
            errors = 0;
            words_seen = 0;
            records = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (votes[i]) votes[i] = 0;
            foreach (rank_sums[i]) rank_sums[i] = 0;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void write_reg(logic [2:0] index, logic [63:0] data);
            case (index)
                RegRankCount: rank_count = data[2:0];
                RegRank0:     rank_bits[0] = data[8:0];
                RegRank1:     rank_bits[1] = data[8:0];
                RegRank2:     rank_bits[2] = data[8:0];
                RegRank3:     rank_bits[3] = data[8:0];
                RegFillLow:   fill_low = data;
                RegFillHigh:  fill_high = data;
                default: ;
            endcase
        endfunction

        function int unsigned live_ranks();
            int unsigned n;
            n = rank_count;
            if (n < 1) n = 1;
            if (n > NumRanks) n = NumRanks;
            return n;
        endfunction

        // slice start and length of rank r, returns the whole code length
        function int unsigned slice(int unsigned r, output int unsigned first,
                                    output int unsigned len);
            int unsigned pos;
            int unsigned b;
            pos = 0;
            first = 0;
            len = 0;
            for (int unsigned i = 0; i < live_ranks(); i++) begin
                b = rank_bits[i];
                if (b > 256) b = 256;
                if (b > NumBits - pos) b = NumBits - pos;
                if (i == r) begin
                    first = pos;
                    len = b;
                end
                pos += b;
            end
            return pos;
        endfunction

        function logic [63:0] fmix(logic [63:0] k);
            k = k ^ (k >> 33);
            k = k * Mix1;
            k = k ^ (k >> 33);
            k = k * Mix2;
            k = k ^ (k >> 33);
            return k;
        endfunction

        function longint bump(longint a, longint d);
            longint s;
            s = a + d;
            if (s > VoteMax) return VoteMax;
            if (s < VoteMin) return VoteMin;
            return s;
        endfunction

        function void cast_votes(logic [63:0] seed, int unsigned first, int unsigned count,
                                 longint w);
            logic [63:0] h;
            int unsigned off;
            int unsigned chunk;
            off = 0;
            while (count > 0) begin
                h = fmix(seed);
                chunk = (count < 64) ? count : 64;
                for (int unsigned b = 0; b < chunk; b++)
                    if (first + off + b < NumBits)
                        votes[first + off + b] = bump(votes[first + off + b],
                                                      h[b] ? w : -w);
                count -= chunk;
                off += chunk;
                seed = h;
            end
        endfunction

        function void note_item(logic kind, logic [63:0] id, logic [2:0] rank,
                                logic [31:0] weight, logic [63:0] uid);
            int unsigned first, len, total, words;
            longint w;
            logic [63:0] src;
            code_word_t cw;
            if (kind == KindFeature) begin
                w = longint'($signed(weight));
                if (rank >= live_ranks()) return;
                rank_sums[rank] = bump(rank_sums[rank], w);
                void'(slice(rank, first, len));
                cast_votes(id, first, len, w);
                return;
            end
            records++;
            // empty ranks get a stand-in feature built from the record id
            for (int unsigned r = 0; r < live_ranks(); r++) begin
                void'(slice(r, first, len));
                if (rank_sums[r] == 0 && len > 0) begin
                    src = (r < 2) ? fill_low : fill_high;
                    w = longint'($signed(r[0] ? src[63:32] : src[31:0]));
                    cast_votes(64'd0 - fmix(uid ^ (64'(r) << 32)), first, len, w);
                end
            end
            total = slice(0, first, len);
            words = (total + 63) / 64;
            if (words == 0) words = 1;
            if (words > 4) words = 4;
            for (int unsigned i = 0; i < words; i++) begin
                cw.code = '0;
                for (int unsigned b = 0; b < 64; b++)
                    if (i * 64 + b < total && votes[i * 64 + b] > 0)
                        cw.code[b] = 1'b1;
                cw.index = i[1:0];
                cw.last = (i + 1 == words);
                pending_words.push_back(cw);
            end
            wipe();
        endfunction

        function void check_word(logic [63:0] code, logic [1:0] index, logic last);
            code_word_t exp_w;
            words_seen++;
            if (pending_words.size() == 0) begin
                $error("code word with none expected: code_word %h", code);
                errors++;
                return;
            end
            exp_w = pending_words.pop_front();
            if (code !== exp_w.code) begin
                $error("code_word expected %h actual %h", exp_w.code, code);
                errors++;
            end
            if (index !== exp_w.index) begin
                $error("word_index expected %0d actual %0d", exp_w.index, index);
                errors++;
            end
            if (last !== exp_w.last) begin
                $error("last_word expected %0d actual %0d", exp_w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    logic [63:0] feat_id;
    logic [2:0]  feature_rank;
    logic [31:0] weight;
    logic [63:0] record_uid;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        out_valid;
    logic [63:0] code_word;
    logic [1:0]  word_index;
    logic        last_word;

    code_scoreboard sb;
    int unsigned cycles;
    int unsigned items_sent;
    bit          no_gaps;

    weighted_simhash_encoder dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .feat_id(feat_id), .feature_rank(feature_rank), .weight(weight),
        .record_uid(record_uid), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .out_valid(out_valid),
        .code_word(code_word), .word_index(word_index), .last_word(last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid)
            sb.check_word(code_word, word_index, last_word);
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_gaps) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    task automatic send(logic k, logic [63:0] id, logic [2:0] rank, logic [31:0] w,
                        logic [63:0] uid);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind = k;
        feat_id = id;
        feature_rank = rank;
        weight = w;
        record_uid = uid;
        start = 1'b1;
        do @(posedge clk); while (busy);
        sb.note_item(k, id, rank, w, uid);
        items_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (Settle) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [63:0] data);
        cfg_index = index;
        cfg_data = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(index, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic setup(logic [2:0] count, logic [8:0] b0, logic [8:0] b1, logic [8:0] b2,
                         logic [8:0] b3, logic [63:0] lo, logic [63:0] hi);
        drain();
        write_reg(RegRankCount, 64'(count));
        write_reg(RegRank0, 64'(b0));
        write_reg(RegRank1, 64'(b1));
        write_reg(RegRank2, 64'(b2));
        write_reg(RegRank3, 64'(b3));
        write_reg(RegFillLow, lo);
        write_reg(RegFillHigh, hi);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 4000000)) - 2000000);
        endcase
    endfunction

    // one record of random features; rarely a rank out of range
    task automatic random_record(int unsigned max_feats);
        int unsigned n;
        logic [2:0] rank;
        n = $urandom_range(0, max_feats);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                rank = 3'($urandom_range(0, 7));
            else
                rank = 3'($urandom_range(0, sb.live_ranks() - 1));
            send(KindFeature, rand64(), rank, rand_weight(), rand64());
        end
        send(KindFinish, rand64(), 3'($urandom_range(0, 7)), $urandom, rand64());
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        items_sent = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = KindFeature;
        feat_id = '0;
        feature_rank = '0;
        weight = '0;
        record_uid = '0;
        cfg_valid = 1'b0;
        cfg_index = RegRankCount;
        cfg_data = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: one rank of 256 bits
        send(KindFeature, 64'h0, 3'd0, 32'h7fff_ffff, 64'h0);
        send(KindFeature, 64'hffff_ffff_ffff_ffff, 3'd0, 32'h8000_0000, 64'h0);
        send(KindFeature, 64'h8000_0000_0000_0000, 3'd7, 32'h1234_5678, 64'h0);
        send(KindFeature, 64'h7fff_ffff_ffff_ffff, 3'd1, 32'h0000_0001, 64'h0);
        send(KindFeature, 64'h5a5a_a5a5_0f0f_f0f0, 3'd0, 32'h0, 64'h0);
        send(KindFinish, 64'h0, 3'd0, 32'h0, 64'h8000_0000_0000_0000);
        send(KindFinish, 64'hffff_ffff_ffff_ffff, 3'd7, 32'hffff_ffff, 64'h0);
        // weights that cancel leave the rank total at zero
        send(KindFeature, 64'h1111, 3'd0, 32'd5, 64'h0);
        send(KindFeature, 64'h2222, 3'd0, -32'sd5, 64'h0);
        send(KindFinish, 64'h0, 3'd0, 32'h0, 64'h7fff_ffff_ffff_ffff);

        setup(3'd4, 9'd64, 9'd64, 9'd64, 9'd64, {32'h7fff_ffff, 32'h8000_0000},
              {32'h0000_0000, 32'hffff_ffff});
        send(KindFinish, 64'h0, 3'd0, 32'h0, 64'hffff_ffff_ffff_ffff);
        for (int r = 0; r < 4; r++)
            send(KindFeature, rand64(), 3'(r), rand_weight(), 64'h0);
        send(KindFeature, rand64(), 3'd4, 32'd77, 64'h0);
        send(KindFinish, 64'h0, 3'd0, 32'h0, rand64());

        // counts past the limits and slices cut at the end of the code
        setup(3'd7, 9'd511, 9'd300, 9'd5, 9'd0, rand64(), rand64());
        send(KindFeature, rand64(), 3'd1, rand_weight(), 64'h0);
        send(KindFinish, 64'h0, 3'd0, 32'h0, rand64());

        // zero rank count acts as one; no code bits at all
        setup(3'd0, 9'd0, 9'd64, 9'd64, 9'd64, rand64(), rand64());
        send(KindFeature, rand64(), 3'd0, rand_weight(), 64'h0);
        send(KindFinish, 64'h0, 3'd0, 32'h0, rand64());

        setup(3'd3, 9'd1, 9'd127, 9'd63, 9'd256, rand64(), rand64());
        no_gaps = 1'b1;
        for (int i = 0; i < 6; i++)
            random_record(5);
        no_gaps = 1'b0;

        while (items_sent < ItemTarget) begin
            if ($urandom_range(0, 3) == 0)
                setup(3'($urandom_range(0, 7)), 9'($urandom_range(0, 511)),
                      9'($urandom_range(0, 130)), 9'($urandom_range(0, 70)),
                      9'($urandom_range(0, 300)), rand64(), rand64());
            no_gaps = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < 6; i++) begin
                random_record(8);
                // now and then the sender holds off until the block has put out every word
                if ($urandom_range(0, 7) == 0) begin
                    @(negedge clk);
                    start = 1'b0;
                    while (sb.pending() != 0) @(negedge clk);
                end
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (Settle) @(posedge clk);
        $display("run: %0d items, %0d records, %0d code words checked",
                 items_sent, sb.records, sb.words_seen);
        $display("covered clamped rank counts, cut and empty slices, stand-in fills");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/wse_pkg.sv
hw/rtl/wse_ram.sv
hw/rtl/wse_mix.sv
hw/rtl/weighted_simhash_encoder.sv
dv/weighted_simhash_encoder_test.sv
